[rtl/core/tbs_pkg.sv]
// ----------------------------------------------------------------------------
// tbs_pkg
// shared types and constants of the token bucket packet shaper
// ----------------------------------------------------------------------------
package tbs_pkg;

	localparam int BUCKET_W  = 24;
	localparam int RATE_W    = 32;
	localparam int PORT_W    = 16;
	localparam int LEN_W     = 16;
	localparam int TAG_W     = 16;
	localparam int ELAPSED_W = 20;
	localparam int TOKEN_W   = 32;
	localparam int KIND_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int ENTRY_W   = TAG_W + LEN_W;

	// elapsed * rate / 1000000 taken as (product >> 6) / 15625, the division done
	// by a rounded-up reciprocal of 15625 scaled by 2^60, one 16 bit slice a cycle
	localparam int PROD_W      = ELAPSED_W + RATE_W;
	localparam int QUOT_W      = 33;
	localparam int PRE_SHIFT   = 6;
	localparam int SCALED_W    = PROD_W - PRE_SHIFT;
	localparam int RECIP_SHIFT = 60;
	localparam int RECIP_W     = 48;
	localparam int CHUNK_W     = 16;
	localparam int ACC_W       = RECIP_SHIFT + QUOT_W;
	localparam int DIV_STEPS   = RECIP_W / CHUNK_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
	localparam logic [RECIP_W-1:0] RECIP_MUL = 48'd73786976294839;
	localparam int US_PER_SEC  = 1000000;

	localparam logic [BUCKET_W-1:0] RESET_BUCKET = 24'd1600000;
	localparam logic [RATE_W-1:0]   RESET_RATE   = 32'd100000000;
	localparam logic [PORT_W-1:0]   RESET_PORT   = 16'd5001;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BUCKET_SIZE = 2'd0,
		REG_RATE        = 2'd1,
		REG_MATCH_PORT  = 2'd2
	} reg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PASSED   = 3'd0,
		KIND_SENT     = 3'd1,
		KIND_QUEUED   = 3'd2,
		KIND_DROPPED  = 3'd3,
		KIND_RELEASED = 3'd4
	} kind_t;

	typedef enum logic {
		ACT_ARRIVAL = 1'b0,
		ACT_TICK    = 1'b1
	} action_t;

	typedef struct packed {
		logic [BUCKET_W-1:0] bucket_size;
		logic [RATE_W-1:0]   rate;
		logic [PORT_W-1:0]   match_port;
	} cfg_t;

	typedef struct packed {
		action_t              action;
		logic                 shaped;
		logic [LEN_W-1:0]     len;
		logic [TAG_W-1:0]     tag;
		logic [ELAPSED_W-1:0] elapsed;
	} cmd_t;

endpackage

[rtl/core/tbs_ram.sv]
// ----------------------------------------------------------------------------
// tbs_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[rtl/core/tbs_front.sv]
// ----------------------------------------------------------------------------
// tbs_front
// accepts commands, marks shaped arrivals and holds the commands in a two entry queue
// ----------------------------------------------------------------------------
module tbs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tbs_pkg::cfg_t                 cfg,
	input  logic                          start,
	input  logic                          action,
	input  logic                          is_tcp,
	input  logic [tbs_pkg::PORT_W-1:0]    dest_port,
	input  logic [tbs_pkg::LEN_W-1:0]     packet_len,
	input  logic [tbs_pkg::TAG_W-1:0]     packet_tag,
	input  logic [tbs_pkg::ELAPSED_W-1:0] elapsed_us,
	output logic                          busy,
	output logic                          cmd_valid,
	output tbs_pkg::cmd_t                 cmd,
	input  logic                          cmd_pop
);

	tbs_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;
	logic          push;
	tbs_pkg::cmd_t cmd_in;

	assign busy      = (fill_q == 2'd2);
	assign push      = start && !busy;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];

	always_comb begin
		cmd_in.action  = tbs_pkg::action_t'(action);
		cmd_in.shaped  = is_tcp && (dest_port == cfg.match_port);
		cmd_in.len     = packet_len;
		cmd_in.tag     = packet_tag;
		cmd_in.elapsed = elapsed_us;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, cmd_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[rtl/core/tbs_back.sv]
// ----------------------------------------------------------------------------
// tbs_back
// token bucket, packet queue and release sequencer
// ----------------------------------------------------------------------------
module tbs_back #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tbs_pkg::cfg_t              cfg,
	input  logic                       cmd_valid,
	input  tbs_pkg::cmd_t              cmd,
	output logic                       cmd_pop,
	output logic                       valid,
	output logic [tbs_pkg::KIND_W-1:0] kind,
	output logic [tbs_pkg::TAG_W-1:0]  tag,
	output logic [tbs_pkg::LEN_W-1:0]  length,
	output logic                       last
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int TW = tbs_pkg::TOKEN_W;
	localparam int PW = tbs_pkg::PROD_W;
	localparam int XW = tbs_pkg::SCALED_W;
	localparam int RW = tbs_pkg::RECIP_W;
	localparam int KW = tbs_pkg::CHUNK_W;
	localparam int MW = tbs_pkg::ACC_W;
	localparam int DW = tbs_pkg::DIV_CNT_W;
	localparam int QW = tbs_pkg::QUOT_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_ADD  = 4'b0100,
		ST_CHK  = 4'b1000
	} state_t;

	state_t                            state_q, state_d;
	logic [TW-1:0]                     token_q, token_d;
	logic [AW-1:0]                     head_q, head_d;
	logic [CW-1:0]                     count_q, count_d;
	logic [XW-1:0]                     scaled_q, scaled_d;
	logic [RW-1:0]                     recip_q, recip_d;
	logic [MW-1:0]                     acc_q, acc_d;
	logic [DW-1:0]                     div_cnt_q, div_cnt_d;
	logic                              pend_q, pend_d;
	logic [tbs_pkg::ENTRY_W-1:0]       pend_entry_q, pend_entry_d;

	logic [SW-1:0]                     tail_sum;
	logic [AW-1:0]                     tail;
	logic [AW-1:0]                     head_inc;
	logic [AW-1:0]                     rd_addr;
	logic [tbs_pkg::ENTRY_W-1:0]       rd_data;
	logic                              wr_en;
	logic [tbs_pkg::LEN_W-1:0]         rd_len;
	logic                              release_now;
	logic [PW-1:0]                     prod;
	logic [XW+KW-1:0]                  part;
	logic [TW+1:0]                     sum;
	logic [TW-1:0]                     bucket_ext;

	logic                              emit;
	tbs_pkg::kind_t                    emit_kind;
	logic [tbs_pkg::TAG_W-1:0]         emit_tag;
	logic [tbs_pkg::LEN_W-1:0]         emit_len;
	logic                              emit_last;

	assign tail_sum   = SW'(head_q) + SW'(count_q);
	assign tail       = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
		: AW'(tail_sum);
	assign head_inc   = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign rd_len     = rd_data[tbs_pkg::LEN_W-1:0];
	assign bucket_ext = TW'(cfg.bucket_size);
	assign release_now = (state_q == ST_CHK) && (count_q != '0)
		&& (TW'(rd_len) < token_q);
	assign rd_addr    = release_now ? head_inc : head_q;
	assign wr_en      = (state_q == ST_IDLE) && cmd_valid && (cmd.action == tbs_pkg::ACT_ARRIVAL)
		&& cmd.shaped && !((token_q >= TW'(cmd.len)) && (count_q == '0))
		&& (count_q < CW'(QUEUE_DEPTH));
	assign prod       = PW'(cmd.elapsed) * PW'(cfg.rate);
	// reciprocal multiply for the division by one million, top slice first
	assign part       = (XW+KW)'(scaled_q) * (XW+KW)'(recip_q[RW-1 -: KW]);
	assign sum        = (TW+2)'(token_q) + (TW+2)'(acc_q[tbs_pkg::RECIP_SHIFT +: QW]);

	tbs_ram #(
		.WIDTH(tbs_pkg::ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(tail),
		.wr_data({cmd.tag, cmd.len}),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		state_d      = state_q;
		token_d      = token_q;
		head_d       = head_q;
		count_d      = count_q;
		scaled_d     = scaled_q;
		recip_d      = recip_q;
		acc_d        = acc_q;
		div_cnt_d    = div_cnt_q;
		pend_d       = pend_q;
		pend_entry_d = pend_entry_q;
		cmd_pop      = 1'b0;
		emit         = 1'b0;
		emit_kind    = tbs_pkg::KIND_PASSED;
		emit_tag     = cmd.tag;
		emit_len     = cmd.len;
		emit_last    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.action == tbs_pkg::ACT_ARRIVAL) begin
						emit = 1'b1;
						priority if (!cmd.shaped) begin
							emit_kind = tbs_pkg::KIND_PASSED;
						end else if ((token_q >= TW'(cmd.len)) && (count_q == '0)) begin
							emit_kind = tbs_pkg::KIND_SENT;
							token_d   = token_q - TW'(cmd.len);
						end else if (count_q < CW'(QUEUE_DEPTH)) begin
							emit_kind = tbs_pkg::KIND_QUEUED;
							count_d   = count_q + CW'(1);
						end else begin
							emit_kind = tbs_pkg::KIND_DROPPED;
						end
					end else begin
						scaled_d  = prod[PW-1:tbs_pkg::PRE_SHIFT];
						recip_d   = tbs_pkg::RECIP_MUL;
						acc_d     = '0;
						div_cnt_d = '0;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				acc_d     = {acc_q[MW-KW-1:0], {KW{1'b0}}} + MW'(part);
				recip_d   = {recip_q[RW-KW-1:0], {KW{1'b0}}};
				div_cnt_d = div_cnt_q + DW'(1);
				if (div_cnt_q == DW'(tbs_pkg::DIV_STEPS - 1)) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				token_d = (sum[TW+1:TW] != 2'b00) ? '1 : sum[TW-1:0];
				pend_d  = 1'b0;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				emit_kind = tbs_pkg::KIND_RELEASED;
				emit_tag  = pend_entry_q[tbs_pkg::ENTRY_W-1:tbs_pkg::LEN_W];
				emit_len  = pend_entry_q[tbs_pkg::LEN_W-1:0];
				emit      = pend_q;
				if (release_now) begin
					emit_last    = 1'b0;
					token_d      = token_q - TW'(rd_len);
					head_d       = head_inc;
					count_d      = count_q - CW'(1);
					pend_d       = 1'b1;
					pend_entry_d = rd_data;
				end else begin
					emit_last = 1'b1;
					pend_d    = 1'b0;
					if ((count_q == '0) && (token_q >= bucket_ext)) begin
						token_d = bucket_ext;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			token_q   <= TW'(tbs_pkg::RESET_BUCKET);
			head_q    <= '0;
			count_q   <= '0;
			div_cnt_q <= '0;
			pend_q    <= 1'b0;
			valid     <= 1'b0;
		end else begin
			state_q   <= state_d;
			token_q   <= token_d;
			head_q    <= head_d;
			count_q   <= count_d;
			div_cnt_q <= div_cnt_d;
			pend_q    <= pend_d;
			valid     <= emit;
		end
	end

	always_ff @(posedge clk) begin
		scaled_q     <= scaled_d;
		recip_q      <= recip_d;
		acc_q        <= acc_d;
		pend_entry_q <= pend_entry_d;
		kind         <= emit_kind;
		tag          <= emit_tag;
		length       <= emit_len;
		last         <= emit_last;
	end

endmodule

[rtl/core/token_bucket_packet_shaper.sv]
// ----------------------------------------------------------------------------
// token_bucket_packet_shaper
// token bucket shaper with a queue of waiting packets, front and back halves
// ----------------------------------------------------------------------------
// an arrival gives one result, registered at the outputs once the back half takes it
// a tick takes a multiply, the reciprocal multiply for the division by one
// million and one saturating add; its releases then follow at one per cycle,
// the last of them marked by last
// reset loads default registers, a full bucket and an empty queue at once
// up to two commands wait in front; the receiver cannot stall the results
module token_bucket_packet_shaper #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [tbs_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [tbs_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic                           start,
	output logic                           busy,
	input  logic                           action,
	input  logic                           is_tcp,
	input  logic [tbs_pkg::PORT_W-1:0]     dest_port,
	input  logic [tbs_pkg::LEN_W-1:0]      packet_len,
	input  logic [tbs_pkg::TAG_W-1:0]      packet_tag,
	input  logic [tbs_pkg::ELAPSED_W-1:0]  elapsed_us,
	output logic                           valid,
	output logic [tbs_pkg::KIND_W-1:0]     kind,
	output logic [tbs_pkg::TAG_W-1:0]      tag,
	output logic [tbs_pkg::LEN_W-1:0]      length,
	output logic                           last
);

	tbs_pkg::cfg_t cfg_q;
	logic          cmd_valid;
	tbs_pkg::cmd_t cmd;
	logic          cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bucket_size <= tbs_pkg::RESET_BUCKET;
			cfg_q.rate        <= tbs_pkg::RESET_RATE;
			cfg_q.match_port  <= tbs_pkg::RESET_PORT;
		end else if (wr_en) begin
			unique case (wr_index)
				tbs_pkg::REG_BUCKET_SIZE: cfg_q.bucket_size <= wr_data[tbs_pkg::BUCKET_W-1:0];
				tbs_pkg::REG_RATE:        cfg_q.rate        <= wr_data[tbs_pkg::RATE_W-1:0];
				tbs_pkg::REG_MATCH_PORT:  cfg_q.match_port  <= wr_data[tbs_pkg::PORT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (start),
		.action    (action),
		.is_tcp    (is_tcp),
		.dest_port (dest_port),
		.packet_len(packet_len),
		.packet_tag(packet_tag),
		.elapsed_us(elapsed_us),
		.busy      (busy),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	tbs_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.valid    (valid),
		.kind     (kind),
		.tag      (tag),
		.length   (length),
		.last     (last)
	);

endmodule
